>>> hw/rtl/kda_pkg.sv
// kda_pkg: shared types and codes of the keypad debounce / auto-repeat block.
// No dependencies; imported by the channel interfaces and the top level.
package kda_pkg;

   localparam int unsigned KeyCount = 4;

   typedef logic [KeyCount-1:0] keys_type;
   typedef logic [7:0]          count_type;
   typedef logic [2:0]          op_type;
   typedef logic [1:0]          reg_index_type;

   // command codes
   localparam op_type OP_TICK        = 3'd0;
   localparam op_type OP_FLUSH       = 3'd1;
   localparam op_type OP_STOP_COUNT  = 3'd2;
   localparam op_type OP_CLEAR_PRESS = 3'd3;
   localparam op_type OP_TEST_LEVEL  = 3'd4;
   localparam op_type OP_TAKE_PRESS  = 3'd5;
   localparam op_type OP_TAKE_HOLD   = 3'd6;

   // register indexes
   localparam reg_index_type REG_SCAN_PERIOD     = 2'd0;
   localparam reg_index_type REG_HOLD_THRESHOLD  = 2'd1;
   localparam reg_index_type REG_REPEAT_INTERVAL = 2'd2;
   localparam reg_index_type REG_REPEAT_KEYS     = 2'd3;

   // register reset values
   localparam count_type SCAN_PERIOD_RESET     = 8'd10;
   localparam count_type HOLD_THRESHOLD_RESET  = 8'd50;
   localparam count_type REPEAT_INTERVAL_RESET = 8'd10;
   localparam keys_type  REPEAT_KEYS_RESET     = 4'b0011;

   localparam count_type COUNT_MAX = 8'hFF;

endpackage

>>> hw/rtl/kda_channels.sv
// kda_channels: valid/ready channel interfaces for request and response words.
// Depends on kda_pkg for the payload types.
interface kda_req_if;
   logic               valid;
   logic               ready;
   kda_pkg::op_type    op;
   kda_pkg::keys_type  keys_raw;
   kda_pkg::keys_type  key_select;

   modport source (output valid, output op, output keys_raw, output key_select,
                   input ready);
   modport sink   (input valid, input op, input keys_raw, input key_select,
                   output ready);
endinterface

interface kda_rsp_if;
   logic               valid;
   logic               ready;
   logic               answer;
   kda_pkg::keys_type  stable_keys;
   kda_pkg::keys_type  press_events;
   kda_pkg::keys_type  hold_events;
   logic               sample_changed;
   logic               scanned;

   modport source (output valid, output answer, output stable_keys,
                   output press_events, output hold_events,
                   output sample_changed, output scanned, input ready);
   modport sink   (input valid, input answer, input stable_keys,
                   input press_events, input hold_events,
                   input sample_changed, input scanned, output ready);
endinterface

>>> hw/rtl/keypad_debounce_autorepeat.sv
// keypad_debounce_autorepeat: four-key scanner with debounce, hold and repeat.
// Depends on kda_pkg and the channel interfaces in kda_channels.sv.
//
//   channel  direction  handshake            carries
//   req      in         valid/ready          op, keys_raw, key_select
//   rsp      out        valid/ready          answer, levels, events, flags
//   csr      in         APB, pready tied 1   four config registers
//
// One word per cycle: every word is resolved in the cycle it is accepted and
// its response lands in the output register the next cycle.
// req.ready is high while the output register is empty or being drained, so a
// stalled rsp side holds one response and blocks further words.
// Reset (synchronous) clears all key state and loads register defaults.
module keypad_debounce_autorepeat (
   input  logic                      clock,
   input  logic                      reset,
   kda_req_if.sink                   req,
   kda_rsp_if.source                 rsp,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [3:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import kda_pkg::*;

   // config registers
   count_type scan_period_ff, hold_threshold_ff, repeat_interval_ff;
   keys_type  repeat_keys_ff;

   // key state
   count_type tick_wait_ff, tick_wait_in;
   keys_type  last_sample_ff, last_sample_in;
   keys_type  stable_level_ff, stable_level_in;
   keys_type  press_pending_ff, press_pending_in;
   keys_type  hold_pending_ff, hold_pending_in;
   count_type held_scans_ff, held_scans_in;
   logic      changed_ff, changed_in;

   // response register
   logic      rsp_valid_ff;
   logic      answer_ff, answer_in;
   logic      scanned_ff, scanned_in;
   keys_type  rsp_stable_ff, rsp_press_ff, rsp_hold_ff;
   logic      rsp_changed_ff;

   logic          req_accept;
   logic          csr_write;
   reg_index_type csr_index;

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         REG_SCAN_PERIOD:     csr_prdata = {24'd0, scan_period_ff};
         REG_HOLD_THRESHOLD:  csr_prdata = {24'd0, hold_threshold_ff};
         REG_REPEAT_INTERVAL: csr_prdata = {24'd0, repeat_interval_ff};
         REG_REPEAT_KEYS:     csr_prdata = {28'd0, repeat_keys_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff     <= SCAN_PERIOD_RESET;
         hold_threshold_ff  <= HOLD_THRESHOLD_RESET;
         repeat_interval_ff <= REPEAT_INTERVAL_RESET;
         repeat_keys_ff     <= REPEAT_KEYS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SCAN_PERIOD:     scan_period_ff     <= csr_pwdata[7:0];
            REG_HOLD_THRESHOLD:  hold_threshold_ff  <= csr_pwdata[7:0];
            REG_REPEAT_INTERVAL: repeat_interval_ff <= csr_pwdata[7:0];
            REG_REPEAT_KEYS:     repeat_keys_ff     <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   // next state for one word
   always_comb begin
      count_type held_mid;
      tick_wait_in     = tick_wait_ff;
      last_sample_in   = last_sample_ff;
      stable_level_in  = stable_level_ff;
      press_pending_in = press_pending_ff;
      hold_pending_in  = hold_pending_ff;
      held_scans_in    = held_scans_ff;
      changed_in       = changed_ff;
      answer_in        = 1'b0;
      scanned_in       = 1'b0;
      held_mid         = held_scans_ff;

      unique case (req.op)
         OP_TICK: begin
            if (tick_wait_ff != 8'd0) begin
               tick_wait_in = tick_wait_ff - 8'd1;
            end else begin
               // zero period behaves as one
               tick_wait_in = (scan_period_ff != 8'd0) ? scan_period_ff - 8'd1 : 8'd0;
               scanned_in   = 1'b1;
               if (req.keys_raw != last_sample_ff) begin
                  last_sample_in = req.keys_raw;
                  changed_in     = 1'b1;
               end else if (req.keys_raw == '0) begin
                  stable_level_in = '0;
                  hold_pending_in = '0;
                  held_scans_in   = 8'd0;
               end else begin
                  stable_level_in = req.keys_raw;
                  if (held_scans_ff == 8'd0) begin
                     press_pending_in = press_pending_ff | req.keys_raw;
                  end else if (held_scans_ff >= hold_threshold_ff) begin
                     press_pending_in = press_pending_ff | (req.keys_raw & repeat_keys_ff);
                     hold_pending_in  = hold_pending_ff | req.keys_raw;
                     held_mid = (hold_threshold_ff > repeat_interval_ff) ?
                                hold_threshold_ff - repeat_interval_ff : 8'd0;
                  end
                  // saturating count
                  held_scans_in = (held_mid != COUNT_MAX) ? held_mid + 8'd1 : held_mid;
               end
            end
         end
         OP_FLUSH: begin
            press_pending_in = '0;
            stable_level_in  = '0;
            hold_pending_in  = '0;
            held_scans_in    = 8'd0;
         end
         OP_STOP_COUNT: held_scans_in = 8'd1;
         OP_CLEAR_PRESS: press_pending_in = press_pending_ff & ~req.key_select;
         OP_TEST_LEVEL: answer_in = (stable_level_ff & req.key_select) == req.key_select;
         OP_TAKE_PRESS: begin
            if ((press_pending_ff & req.key_select) == req.key_select) begin
               press_pending_in = press_pending_ff & ~req.key_select;
               answer_in        = 1'b1;
            end
         end
         OP_TAKE_HOLD: begin
            if ((hold_pending_ff & req.key_select) == req.key_select) begin
               hold_pending_in = hold_pending_ff & ~req.key_select;
               answer_in       = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_wait_ff     <= 8'd0;
         last_sample_ff   <= '0;
         stable_level_ff  <= '0;
         press_pending_ff <= '0;
         hold_pending_ff  <= '0;
         held_scans_ff    <= 8'd0;
         changed_ff       <= 1'b0;
      end else if (req_accept) begin
         tick_wait_ff     <= tick_wait_in;
         last_sample_ff   <= last_sample_in;
         stable_level_ff  <= stable_level_in;
         press_pending_ff <= press_pending_in;
         hold_pending_ff  <= hold_pending_in;
         held_scans_ff    <= held_scans_in;
         changed_ff       <= changed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         answer_ff      <= answer_in;
         scanned_ff     <= scanned_in;
         rsp_stable_ff  <= stable_level_in;
         rsp_press_ff   <= press_pending_in;
         rsp_hold_ff    <= hold_pending_in;
         rsp_changed_ff <= changed_in;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.answer         = answer_ff;
   assign rsp.scanned        = scanned_ff;
   assign rsp.stable_keys    = rsp_stable_ff;
   assign rsp.press_events   = rsp_press_ff;
   assign rsp.hold_events    = rsp_hold_ff;
   assign rsp.sample_changed = rsp_changed_ff;

`ifndef SYNTHESIS
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   a_changed_sticky: assert property (@(posedge clock) disable iff (reset)
      changed_ff |=> changed_ff)
      else $error("sample_changed flag dropped");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req.op == OP_FLUSH) |=>
      (stable_level_ff == '0 && press_pending_ff == '0 &&
       hold_pending_ff == '0 && held_scans_ff == 8'd0))
      else $error("flush left key state behind");

   a_tick_countdown: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req.op == OP_TICK && tick_wait_ff != 8'd0) |=>
      (tick_wait_ff == $past(tick_wait_ff) - 8'd1 && !scanned_ff))
      else $error("tick countdown misstep");
`endif

endmodule
